// ===== rtl/bstfa_pkg.sv =====
// Package for the bucketed sorted record table.
// Holds sizes, status codes and mode codes; no dependencies.
package bstfa_pkg;
  localparam int unsigned BucketBits  = 8;
  localparam int unsigned ListDepth   = 64;
  localparam int unsigned RecordDepth = 16384;

  localparam int unsigned BucketCount = 1 << BucketBits;
  localparam int unsigned PosW   = $clog2(ListDepth);
  localparam int unsigned FillW  = $clog2(ListDepth + 1);
  localparam int unsigned RecW   = $clog2(RecordDepth);
  localparam int unsigned CountW = $clog2(RecordDepth + 1);
  localparam int unsigned ListW  = BucketBits + PosW;

  typedef enum logic [1:0] {
    ModeFind      = 2'd0,
    ModeAdd       = 2'd1,
    ModeFindOrAdd = 2'd2,
    ModeClear     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StFound      = 3'd0,
    StNotFound   = 3'd1,
    StAdded      = 3'd2,
    StBucketFull = 3'd3,
    StStoreFull  = 3'd4,
    StCleared    = 3'd5
  } status_e;
endpackage

// ===== rtl/bucketed_sorted_table_find_or_add.sv =====
// Top level of the bucketed sorted record table: find, add, find-or-add, clear.
// Depends on bstfa_pkg. Lists and records live in internal memories.
//
// channel | handshake          | fields
// --------+--------------------+-------------------------------------------------
// command | start_i / busy_o   | mode, bucket, key_high/low, payload_a/b/c
// result  | done_o (one cycle) | status, found_payload_a/b/c, total_records
//
// A find reads the fill (SFill), then runs a binary search in which each probe
// passes through SProbe, SRec and SCmp (list read, record read, compare), up to
// 7 probes for 64 entries, and ends with the match check in SList, SHit and SDecide.
// An insert then moves list entries up one slot, each through SShRd and SShWr,
// writes the list slot, the record and the fill in SIns and reports in SData.
// Clear walks all bucket fill entries, one a cycle. After reset the fills are
// cleared by the same walk with busy_o high. done_o follows the last busy cycle;
// the receiver cannot stall results.
module bucketed_sorted_table_find_or_add
  import bstfa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  bucket_i,
  input  logic [7:0]  key_high_i,
  input  logic [63:0] key_low_i,
  input  logic [63:0] payload_a_i,
  input  logic [63:0] payload_b_i,
  input  logic [55:0] payload_c_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [63:0] found_payload_a_o,
  output logic [63:0] found_payload_b_o,
  output logic [55:0] found_payload_c_o,
  output logic [14:0] total_records_o
);
  typedef enum logic [12:0] {
    SClr    = 13'b0000000000001,
    SIdle   = 13'b0000000000010,
    SFill   = 13'b0000000000100,
    SProbe  = 13'b0000000001000,
    SList   = 13'b0000000010000,
    SRec    = 13'b0000000100000,
    SCmp    = 13'b0000001000000,
    SDecide = 13'b0000010000000,
    SShRd   = 13'b0000100000000,
    SShWr   = 13'b0001000000000,
    SIns    = 13'b0010000000000,
    SData   = 13'b0100000000000,
    SHit    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [FillW-1:0]  fill_mem [BucketCount];
  logic [RecW-1:0]   list_mem [BucketCount*ListDepth];
  logic [7:0]        kh_mem   [RecordDepth];
  logic [63:0]       kl_mem   [RecordDepth];
  logic [63:0]       da_mem   [RecordDepth];
  logic [63:0]       db_mem   [RecordDepth];
  logic [55:0]       dc_mem   [RecordDepth];

  logic [1:0]             mode_q;
  logic [BucketBits-1:0]  bkt_q;
  logic [7:0]             kh_q;
  logic [63:0]            kl_q, pa_q, pb_q;
  logic [55:0]            pc_q;
  logic [FillW-1:0]       fill_q, first_q, cnt_q, idx_q;
  logic [FillW-1:0]       fill_rd_q;
  logic [RecW-1:0]        list_rd_q;
  logic [7:0]             rkh_q;
  logic [63:0]            rkl_q;
  logic [CountW-1:0]      stored_q;
  logic [BucketBits-1:0]  clr_q;

  logic        done_q;
  logic [2:0]  status_q;
  logic [63:0] oa_q, ob_q;
  logic [55:0] oc_q;
  logic [63:0] ha_q, hb_q;
  logic [55:0] hc_q;

  // memory control
  logic                   fill_we, list_we;
  logic [BucketBits-1:0]  fill_wa;
  logic [FillW-1:0]       fill_wd;
  logic [ListW-1:0]       list_ra, list_wa;
  logic [RecW-1:0]        list_wd;
  logic                   rec_we;
  logic [RecW-1:0]        rec_wa;

  logic [FillW-1:0] half, mid;
  assign half = cnt_q >> 1;
  assign mid  = first_q + half;

  logic lt, eq, match;
  assign lt    = (rkh_q != kh_q) ? (rkh_q < kh_q) : (rkl_q < kl_q);
  assign eq    = (rkh_q == kh_q) && (rkl_q == kl_q);
  // record of list[first] is valid in SDecide
  assign match = (first_q < fill_q) && eq;

  function automatic logic [ListW-1:0] laddr(input logic [BucketBits-1:0] b,
                                             input logic [FillW-1:0] p);
    laddr = {b, p[PosW-1:0]};
  endfunction

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    fill_rd_q <= fill_mem[bucket_i[BucketBits-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (list_we) list_mem[list_wa] <= list_wd;
    list_rd_q <= list_mem[list_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      kh_mem[rec_wa] <= kh_q;
      kl_mem[rec_wa] <= kl_q;
      da_mem[rec_wa] <= pa_q;
      db_mem[rec_wa] <= pb_q;
      dc_mem[rec_wa] <= pc_q;
    end
    rkh_q <= kh_mem[list_rd_q];
    rkl_q <= kl_mem[list_rd_q];
    oa_q  <= da_mem[list_rd_q];
    ob_q  <= db_mem[list_rd_q];
    oc_q  <= dc_mem[list_rd_q];
  end

  always_comb begin
    state_d = state_q;
    fill_we = 1'b0;
    fill_wa = bkt_q;
    fill_wd = '0;
    list_we = 1'b0;
    list_wa = laddr(bkt_q, idx_q);
    list_wd = list_rd_q;
    list_ra = laddr(bkt_q, mid);
    rec_we  = 1'b0;
    rec_wa  = stored_q[RecW-1:0];
    case (state_q)
      SClr: begin
        fill_we = 1'b1;
        fill_wa = clr_q;
        if (clr_q == BucketBits'(BucketCount - 1)) state_d = SIdle;
      end
      SIdle: if (start_i) state_d = (mode_e'(mode_i) == ModeClear) ? SClr : SFill;
      SFill:   state_d = SProbe;
      SProbe:  state_d = (cnt_q == '0) ? SList : SRec;
      SRec:    state_d = SCmp;
      SCmp:    state_d = SProbe;
      SList:   state_d = SHit;
      SHit:    state_d = SDecide;
      SDecide: begin
        if (match && mode_e'(mode_q) != ModeAdd) state_d = SIdle;
        else if (mode_e'(mode_q) == ModeFind) state_d = SIdle;
        else if (fill_q >= FillW'(ListDepth)) state_d = SIdle;
        else if (stored_q >= CountW'(RecordDepth)) state_d = SIdle;
        else state_d = (fill_q == first_q) ? SIns : SShRd;
      end
      SShRd: begin
        list_ra = laddr(bkt_q, idx_q - FillW'(1));
        state_d = SShWr;
      end
      SShWr: begin
        list_we = 1'b1;
        state_d = (idx_q - FillW'(1) == first_q) ? SIns : SShRd;
      end
      SIns: begin
        list_we = 1'b1;
        list_wa = laddr(bkt_q, first_q);
        list_wd = stored_q[RecW-1:0];
        rec_we  = 1'b1;
        fill_we = 1'b1;
        fill_wd = fill_q + FillW'(1);
        state_d = SData;
      end
      SData:   state_d = SIdle;
      default: state_d = SIdle;
    endcase
    if (state_q == SList) list_ra = laddr(bkt_q, first_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SClr;
      clr_q    <= '0;
      stored_q <= '0;
      done_q   <= 1'b0;
      status_q <= StNotFound;
      mode_q   <= ModeFind;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        SClr: begin
          clr_q <= clr_q + BucketBits'(1);
          if (clr_q == BucketBits'(BucketCount - 1) && mode_e'(mode_q) == ModeClear) begin
            done_q   <= 1'b1;
            status_q <= StCleared;
          end
        end
        SIdle: if (start_i) begin
          mode_q <= mode_i;
          if (mode_e'(mode_i) == ModeClear) begin
            stored_q <= '0;
            clr_q    <= '0;
          end
        end
        SDecide: begin
          if (match && mode_e'(mode_q) != ModeAdd) begin
            done_q <= 1'b1; status_q <= StFound;
          end else if (mode_e'(mode_q) == ModeFind) begin
            done_q <= 1'b1; status_q <= StNotFound;
          end else if (fill_q >= FillW'(ListDepth)) begin
            done_q <= 1'b1; status_q <= StBucketFull;
          end else if (stored_q >= CountW'(RecordDepth)) begin
            done_q <= 1'b1; status_q <= StStoreFull;
          end
        end
        SIns: stored_q <= stored_q + CountW'(1);
        SData: begin
          done_q <= 1'b1; status_q <= StAdded;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: if (start_i) begin
        bkt_q  <= bucket_i[BucketBits-1:0];
        kh_q   <= key_high_i;
        kl_q   <= key_low_i;
        pa_q   <= payload_a_i;
        pb_q   <= payload_b_i;
        pc_q   <= payload_c_i;
      end
      SFill: begin
        // fill read issued on the accept edge is ready in SFill
        fill_q  <= fill_rd_q;
        first_q <= '0;
        cnt_q   <= fill_rd_q;
      end
      SCmp: begin
        if (lt) begin
          first_q <= mid + FillW'(1);
          cnt_q   <= cnt_q - half - FillW'(1);
        end else begin
          cnt_q <= half;
        end
      end
      SDecide: begin
        idx_q <= fill_q;
        // hold the payload of list[first] for the result cycle
        ha_q  <= oa_q;
        hb_q  <= ob_q;
        hc_q  <= oc_q;
      end
      SShWr: idx_q <= idx_q - FillW'(1);
      default: ;
    endcase
  end

  assign busy_o            = (state_q != SIdle);
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign found_payload_a_o = (status_q == StFound) ? ha_q : 64'd0;
  assign found_payload_b_o = (status_q == StFound) ? hb_q : 64'd0;
  assign found_payload_c_o = (status_q == StFound) ? hc_q : 56'd0;
  assign total_records_o   = 15'(stored_q);
endmodule

// ===== tb/tb_top.sv =====
// Testbench for bucketed_sorted_table_find_or_add: directed and random transactions
// checked against an in-bench table model. Depends on bstfa_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_top
  import bstfa_pkg::*;
();

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] pa;
    logic [63:0] pb;
    logic [55:0] pc;
    logic [14:0] total;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  mode_i = '0;
  logic [7:0]  bucket_i = '0;
  logic [7:0]  key_high_i = '0;
  logic [63:0] key_low_i = '0;
  logic [63:0] payload_a_i = '0;
  logic [63:0] payload_b_i = '0;
  logic [55:0] payload_c_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [63:0] found_payload_a_o;
  logic [63:0] found_payload_b_o;
  logic [55:0] found_payload_c_o;
  logic [14:0] total_records_o;

  bucketed_sorted_table_find_or_add dut (.*);

  initial forever #4 clk_i = ~clk_i;

  // table model
  int unsigned  fill_q[BucketCount];
  int unsigned  slot_q[BucketCount][ListDepth];
  logic [7:0]   rkh[RecordDepth];
  logic [63:0]  rkl[RecordDepth];
  logic [63:0]  rda[RecordDepth];
  logic [63:0]  rdb[RecordDepth];
  logic [55:0]  rdc[RecordDepth];
  int unsigned  rec_count;

  outcome_t pending_outcomes[$];
  int       mismatches;
  int       send_gap_pct;
  // keys of the first 200 non-find commands, for hits
  logic [71:0] key_pool[$];

  function automatic logic key_lt(int unsigned r, logic [71:0] k);
    return {rkh[r], rkl[r]} < k;
  endfunction

  function automatic outcome_t table_outcome(mode_e m, logic [7:0] b, logic [71:0] k,
                                             logic [63:0] a, logic [63:0] bb,
                                             logic [55:0] c);
    outcome_t o;
    int unsigned fl, first, cnt, half, mid, r;
    logic hit;
    o = '0;
    if (m == ModeClear) begin
      foreach (fill_q[i]) fill_q[i] = 0;
      rec_count = 0;
      o.status = StCleared;
    end else begin
      fl = fill_q[b];
      first = 0;
      cnt = fl;
      while (cnt > 0) begin
        half = cnt / 2;
        mid = first + half;
        if (key_lt(slot_q[b][mid], k)) begin
          first = mid + 1;
          cnt -= half + 1;
        end else cnt = half;
      end
      hit = (first < fl) && ({rkh[slot_q[b][first]], rkl[slot_q[b][first]]} == k);
      if (m != ModeAdd && hit) begin
        r = slot_q[b][first];
        o.status = StFound;
        o.pa = rda[r];
        o.pb = rdb[r];
        o.pc = rdc[r];
      end else if (m == ModeFind) o.status = StNotFound;
      else if (fl >= ListDepth) o.status = StBucketFull;
      else if (rec_count >= RecordDepth) o.status = StStoreFull;
      else begin
        r = rec_count;
        for (int unsigned i = fl; i > first; i--) slot_q[b][i] = slot_q[b][i-1];
        slot_q[b][first] = r;
        {rkh[r], rkl[r]} = k;
        rda[r] = a;
        rdb[r] = bb;
        rdc[r] = c;
        fill_q[b] = fl + 1;
        rec_count++;
        o.status = StAdded;
      end
    end
    o.total = rec_count[14:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // check each result transaction
  always @(posedge clk_i) begin
    outcome_t w;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0)
        report_mismatch("unexpected result", 64'(status_o), 64'd0);
      else begin
        w = pending_outcomes.pop_front();
        if (status_o !== w.status)
          report_mismatch("status", 64'(status_o), 64'(w.status));
        if (found_payload_a_o !== w.pa) report_mismatch("payload_a", found_payload_a_o, w.pa);
        if (found_payload_b_o !== w.pb) report_mismatch("payload_b", found_payload_b_o, w.pb);
        if (found_payload_c_o !== w.pc)
          report_mismatch("payload_c", 64'(found_payload_c_o), 64'(w.pc));
        if (total_records_o !== w.total)
          report_mismatch("total_records", 64'(total_records_o), 64'(w.total));
      end
    end
  end

  task automatic send_command(mode_e m, logic [7:0] b, logic [71:0] k,
                              logic [63:0] a, logic [63:0] bb, logic [55:0] c);
    // leave the edge of the previous transaction before driving again
    @(posedge clk_i);
    while ($urandom_range(99) < send_gap_pct) @(posedge clk_i);
    start_i <= 1'b1;
    mode_i <= m;
    bucket_i <= b;
    {key_high_i, key_low_i} <= k;
    payload_a_i <= a;
    payload_b_i <= bb;
    payload_c_i <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_outcomes.insert(pending_outcomes.size(), table_outcome(m, b, k, a, bb, c));
    if (m != ModeFind && key_pool.size() < 200) key_pool.insert(key_pool.size(), k);
    start_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_command(ModeFind, 8'h00, '0, '0, '0, '0);
    send_command(ModeAdd, 8'h00, '0, '1, '1, '1);
    send_command(ModeFind, 8'h00, '0, '0, '0, '0);
    send_command(ModeAdd, 8'hFF, '1, 64'h0123456789ABCDEF, '0, 56'h5A5A5A5A5A5A5A);
    send_command(ModeFindOrAdd, 8'hFF, '1, '0, '0, '0);
    send_command(ModeFindOrAdd, 8'hFF, 72'h80_0000000000000000, '1, '0, '1);
    send_command(ModeAdd, 8'hFF, '1, 64'h1, 64'h2, 56'h3);          // duplicate key
    send_command(ModeFind, 8'hFF, '1, '0, '0, '0);
    send_command(ModeFind, 8'hFF, 72'h7F_FFFFFFFFFFFFFFFF, '0, '0, '0);
    send_command(ModeClear, 8'h00, '0, '0, '0, '0);
    send_command(ModeFind, 8'hFF, '1, '0, '0, '0);
    send_command(ModeClear, 8'hFF, '1, '1, '1, '1);
  endtask

  // fill one bucket past its depth, then probe it
  task automatic test_bucket_full();
    for (int i = 0; i < ListDepth + 3; i++)
      send_command(ModeFindOrAdd, 8'h5A, {8'($urandom_range(3)), rand64()}, rand64(),
                   rand64(), 56'(rand64()));
    send_command(ModeAdd, 8'h5A, '0, '0, '0, '0);
    send_command(ModeFind, 8'h5A, '0, '0, '0, '0);
  endtask

  task automatic test_random(int n);
    mode_e m;
    logic [71:0] k;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      m = sel < 35 ? ModeFind : sel < 65 ? ModeAdd : sel < 99 ? ModeFindOrAdd : ModeClear;
      if (key_pool.size() > 0 && $urandom_range(1)) k = key_pool[$urandom_range(key_pool.size()-1)];
      else if ($urandom_range(1)) k = {8'($urandom_range(3)), 64'($urandom_range(15))};
      else k = {8'($urandom), rand64()};
      send_command(m, 8'($urandom_range(15) == 0 ? $urandom : $urandom_range(7)), k,
                   rand64(), rand64(), 56'(rand64()));
    end
  endtask

  initial begin
    #400ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    mismatches = 0;
    send_gap_pct = 22;
    rec_count = 0;
    foreach (fill_q[i]) fill_q[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_bucket_full();
    test_random(560);
    send_gap_pct = 67;
    test_random(560);
    send_gap_pct = 0;
    test_random(560);
    while (pending_outcomes.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/bstfa_pkg.sv
rtl/bucketed_sorted_table_find_or_add.sv
tb/tb_top.sv
